// ===== rtl/bsmx_pkg.sv =====
// Shared types and constants for the byte stream multiply-xor hash.
package bsmx_pkg;

    localparam logic [63:0] K0 = 64'h15459B19A5ED5DBB;
    localparam logic [63:0] K1 = 64'hAAA360CB31A60D5D;
    localparam logic [63:0] K2 = 64'h003BDC7DF5E62165;
    localparam logic [63:0] K3 = 64'h7FCC734CAA4A91DD;
    localparam logic [63:0] K4 = 64'h1FC221792E40C189;

    localparam int unsigned SHIFT_A = 27;
    localparam int unsigned SHIFT_B = 33;

    // multiplier step count: operand latch, three partial products, final add
    localparam logic [2:0] MUL_LAST = 3'd5;

    // work handed from the front to the back
    typedef struct packed {
        logic        blk;    // a full 16-byte block is to be mixed
        logic        fin;    // message ends: finalize after any block mix
        logic [63:0] len;    // total length after this transaction
        logic [63:0] w0;     // bytes 0..7, masked to the tail where finalizing
        logic [63:0] w1;     // bytes 8..15
    } cmd_t;

endpackage

// ===== rtl/bsmx_front.sv =====
// Front: gathers bytes into the block buffer, counts length, issues work.
module bsmx_front
    import bsmx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] data_byte,
    input  logic       byte_valid,
    input  logic       last_item,
    input  logic       accept,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [7:0]  buf_reg [16];
    logic [63:0] len_reg;
    logic [63:0] len_next;
    logic [63:0] len_inc;
    logic [3:0]  idx;
    logic [3:0]  r_new;
    logic        blk;
    logic [7:0]  byte_sel [16];

    assign idx     = len_reg[3:0];
    assign len_inc = len_reg + {63'd0, byte_valid};
    assign r_new   = len_inc[3:0];
    assign blk     = byte_valid && (r_new == 4'd0);

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            if (byte_valid && (idx == 4'(i)))
                byte_sel[i] = data_byte;
            else
                byte_sel[i] = buf_reg[i];
            // bytes past the tail are stale from earlier blocks
            if (!(blk || (4'(i) < r_new)))
                byte_sel[i] = 8'd0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cmd.w0[8*i +: 8] = byte_sel[i];
            cmd.w1[8*i +: 8] = byte_sel[i+8];
        end
        cmd.blk = blk;
        cmd.fin = last_item;
        cmd.len = len_inc;
    end

    assign cmd_push = accept && (blk || last_item);
    assign len_next = last_item ? 64'd0 : len_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= 64'd0;
        else if (accept)
            len_reg <= len_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && byte_valid)
            buf_reg[idx] <= data_byte;
    end

endmodule

// ===== rtl/bsmx_cmdq.sv =====
// Short work queue between the front and the back.
module bsmx_cmdq
    import bsmx_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    output logic q_full,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic q_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== rtl/bsmx_mul.sv =====
// 64x64 low-half multiplier built from one shared 32x32 multiplier.
module bsmx_mul
    import bsmx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        active,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output logic        done,
    output logic [63:0] prod
);

    logic [2:0]  cnt_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] pp_reg;
    logic [63:0] acc_reg;
    logic [31:0] ma;
    logic [31:0] mb;

    assign done = active && (cnt_reg == MUL_LAST);
    assign prod = acc_reg;

    always_comb
    begin
        case (cnt_reg)
            3'd1:    begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
            3'd2:    begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            default: begin ma = a_reg[63:32]; mb = b_reg[31:0];  end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 3'd0;
        else if (!active || done)
            cnt_reg <= 3'd0;
        else
            cnt_reg <= cnt_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (active)
        begin
            case (cnt_reg)
                3'd0:
                begin
                    a_reg <= op_a;
                    b_reg <= op_b;
                end
                3'd1:
                    pp_reg <= {32'd0, ma} * {32'd0, mb};
                3'd2:
                begin
                    acc_reg <= pp_reg;
                    pp_reg  <= {32'd0, ma} * {32'd0, mb};
                end
                3'd3:
                begin
                    acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
                    pp_reg  <= {32'd0, ma} * {32'd0, mb};
                end
                3'd4:
                    acc_reg <= acc_reg + {pp_reg[31:0], 32'd0};
                default:
                    acc_reg <= acc_reg;
            endcase
        end
    end

endmodule

// ===== rtl/bsmx_back.sv =====
// Back: block mixing, tail rule and finalization on the shared multiplier.
module bsmx_back
    import bsmx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  cmd_t        q_data,
    output logic        q_pop,
    input  logic        pop,
    output logic        empty,
    output logic [63:0] hash_value
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_BLK_LO  = 12'b0000_0000_0010,
        S_BLK_HI  = 12'b0000_0000_0100,
        S_FIN     = 12'b0000_0000_1000,
        S_LK      = 12'b0000_0001_0000,
        S_SHORT   = 12'b0000_0010_0000,
        S_TAIL_HI = 12'b0000_0100_0000,
        S_TAIL_LO = 12'b0000_1000_0000,
        S_AV1     = 12'b0001_0000_0000,
        S_AV2     = 12'b0010_0000_0000,
        S_AV_END  = 12'b0100_0000_0000,
        S_OUT     = 12'b1000_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        AV_SHORT = 2'd0,
        AV_LO    = 2'd1,
        AV_HI    = 2'd2
    } av_mode_t;

    state_t      state_reg, state_next;
    av_mode_t    mode_reg, mode_next;
    cmd_t        cmd_reg;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] hi_reg, hi_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] lk_reg, lk_next;
    logic [63:0] h_reg, h_next;
    logic [63:0] res_reg;
    logic        res_valid_reg;
    logic        mul_active;
    logic        mul_done;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic [63:0] prod;
    logic [63:0] fold;
    logic [3:0]  r;
    logic        load_res;

    assign r          = cmd_reg.len[3:0];
    assign fold       = v_reg ^ (v_reg >> SHIFT_B);
    assign empty      = !res_valid_reg;
    assign hash_value = res_reg;
    assign q_pop      = (state_reg == S_IDLE) && !q_empty;
    assign load_res   = (state_reg == S_OUT) && !res_valid_reg;

    assign mul_active = (state_reg == S_BLK_LO) || (state_reg == S_BLK_HI)
                     || (state_reg == S_LK) || (state_reg == S_SHORT)
                     || (state_reg == S_TAIL_HI) || (state_reg == S_TAIL_LO)
                     || (state_reg == S_AV1) || (state_reg == S_AV2);

    always_comb
    begin
        unique case (state_reg)
            S_BLK_LO:  begin mul_a = lo_reg ^ (cmd_reg.w0 + K3); mul_b = K1; end
            S_BLK_HI:  begin mul_a = hi_reg ^ (cmd_reg.w1 + K4); mul_b = K2; end
            S_LK:      begin mul_a = cmd_reg.len;                mul_b = K0; end
            S_SHORT:   begin mul_a = K0 ^ (cmd_reg.w0 + K3);     mul_b = K2; end
            S_TAIL_HI: begin mul_a = hi_reg ^ (cmd_reg.w1 + K1); mul_b = K2; end
            S_TAIL_LO: begin mul_a = lo_reg ^ (cmd_reg.w0 + K3); mul_b = K2; end
            S_AV1:     begin mul_a = v_reg ^ (v_reg >> SHIFT_A); mul_b = K2; end
            S_AV2:     begin mul_a = fold;                       mul_b = K4; end
            default:   begin mul_a = 64'd0;                      mul_b = 64'd0; end
        endcase
    end

    bsmx_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .active (mul_active),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .prod   (prod)
    );

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        v_next     = v_reg;
        lk_next    = lk_reg;
        h_next     = h_reg;
        unique case (state_reg)
            S_IDLE:
                if (!q_empty)
                    state_next = q_data.blk ? S_BLK_LO : S_FIN;
            S_BLK_LO:
                if (mul_done)
                begin
                    lo_next    = prod;
                    state_next = S_BLK_HI;
                end
            S_BLK_HI:
                if (mul_done)
                begin
                    hi_next    = prod;
                    state_next = cmd_reg.fin ? S_FIN : S_IDLE;
                end
            S_FIN:
                if (cmd_reg.len == 64'd0)
                begin
                    h_next     = K4;
                    state_next = S_OUT;
                end
                else
                    state_next = S_LK;
            S_LK:
                if (mul_done)
                begin
                    lk_next = prod;
                    if (cmd_reg.len[63:3] == 61'd0)
                        state_next = S_SHORT;
                    else if (r >= 4'd9)
                        state_next = S_TAIL_HI;
                    else if (r != 4'd0)
                        state_next = S_TAIL_LO;
                    else
                    begin
                        v_next     = lo_reg ^ prod;
                        mode_next  = AV_LO;
                        state_next = S_AV1;
                    end
                end
            S_SHORT:
                if (mul_done)
                begin
                    v_next     = prod ^ lk_reg;
                    mode_next  = AV_SHORT;
                    state_next = S_AV1;
                end
            S_TAIL_HI:
                if (mul_done)
                begin
                    hi_next    = prod;
                    state_next = S_TAIL_LO;
                end
            S_TAIL_LO:
                if (mul_done)
                begin
                    lo_next    = prod;
                    v_next     = prod ^ lk_reg;
                    mode_next  = AV_LO;
                    state_next = S_AV1;
                end
            S_AV1:
                if (mul_done)
                begin
                    v_next     = prod;
                    state_next = S_AV2;
                end
            S_AV2:
                if (mul_done)
                begin
                    v_next     = prod;
                    state_next = S_AV_END;
                end
            S_AV_END:
                case (mode_reg)
                    AV_LO:
                    begin
                        h_next     = lo_reg ^ fold;
                        v_next     = hi_reg ^ lk_reg;
                        mode_next  = AV_HI;
                        state_next = S_AV1;
                    end
                    AV_HI:
                    begin
                        h_next     = h_reg ^ fold;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        h_next     = fold;
                        state_next = S_OUT;
                    end
                endcase
            S_OUT:
                if (!res_valid_reg)
                begin
                    lo_next    = K0;
                    hi_next    = K1;
                    state_next = S_IDLE;
                end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= AV_SHORT;
            lo_reg        <= K0;
            hi_reg        <= K1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            if (load_res)
                res_valid_reg <= 1'b1;
            else if (pop)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg  <= v_next;
        lk_reg <= lk_next;
        h_reg  <= h_next;
        if (q_pop)
            cmd_reg <= q_data;
        if (load_res)
            res_reg <= h_reg;
    end

endmodule

// ===== rtl/byte_stream_multiply_xor_hash64_top.sv =====
// Top level of the streaming 64-bit multiply-xor byte hash.
//
// Bytes enter one per cycle while full is low. Every 16th byte and every last
// item hand a transaction to a small queue; the back end works it on one
// shared 32x32 multiplier, which builds each 64-bit product from three partial
// products. Block mixes keep pace with a steady byte stream, so it never stalls
// on blocks. Finalization is shortest for an empty message, which needs no product,
// and longest for a long message with a tail past 8 bytes: length product, two
// tail mixes, two avalanches. Bytes of the next message keep flowing while a hash
// waits to be popped, until the queue of CMD_DEPTH transactions fills.
module byte_stream_multiply_xor_hash64_top
    import bsmx_pkg::*;
#(
    parameter int CMD_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last_item,
    input  logic        push,
    output logic        full,
    output logic [63:0] hash_value,
    output logic        empty,
    input  logic        pop
);

    logic accept;
    logic cmd_push;
    cmd_t cmd_in;
    cmd_t cmd_out;
    logic q_full;
    logic q_empty;
    logic q_pop;

    assign full   = q_full;
    assign accept = push && !q_full;

    bsmx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .last_item  (last_item),
        .accept     (accept),
        .cmd_push   (cmd_push),
        .cmd        (cmd_in)
    );

    bsmx_cmdq #(.DEPTH(CMD_DEPTH)) u_cmdq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (cmd_out),
        .q_empty (q_empty)
    );

    bsmx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (cmd_out),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .hash_value (hash_value)
    );

endmodule

// ===== rtl/bsmx_checker.sv =====
// Port-level checks for the hash block, bound to the top level.
module bsmx_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        last_item,
    input logic        pop,
    input logic        empty,
    input logic [63:0] hash_value
);

    logic [3:0] pend_reg;
    logic       in_last;
    logic       out_take;

    assign in_last  = push && !full && last_item;
    assign out_take = pop && !empty;

    // messages ended but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 4'd0;
        else if (in_last && !out_take)
            pend_reg <= pend_reg + 4'd1;
        else if (out_take && !in_last)
            pend_reg <= pend_reg - 4'd1;
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(hash_value))
        else $error("waiting hash changed or vanished");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pend_reg != 4'd0)
        else $error("hash shown without an ended message");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && pend_reg == 4'd1 |=> empty)
        else $error("extra hash after the last pending message");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 4'd15)
        else $error("pending message count out of range");

endmodule

bind byte_stream_multiply_xor_hash64_top bsmx_checker u_bsmx_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .last_item  (last_item),
    .pop        (pop),
    .empty      (empty),
    .hash_value (hash_value)
);

// ===== test/byte_stream_multiply_xor_hash64_checker.sv =====
// Checker for the byte stream hash: predicts each message hash and compares results.
module byte_stream_multiply_xor_hash64_checker
    import bsmx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last_item,
    input  logic        push,
    input  logic        full,
    input  logic [63:0] hash_value,
    input  logic        empty,
    input  logic        pop,
    output int          errors,
    output int          hashes_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [7:0]  msg_bytes [16];
    logic [63:0] lane_lo;
    logic [63:0] lane_hi;
    logic [63:0] msg_len;
    logic [63:0] hash_queue [$];

    function automatic logic [63:0] avalanche(logic [63:0] v);
        v = v ^ (v >> SHIFT_A);
        v = v * K2;
        v = v ^ (v >> SHIFT_B);
        v = v * K4;
        v = v ^ (v >> SHIFT_B);
        return v;
    endfunction

    function automatic logic [63:0] le_word(int from, int count);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < count && i < 8; i++)
            v[8*i +: 8] = msg_bytes[(from + i) & 15];
        return v;
    endfunction

    function automatic logic [63:0] finish_hash();
        logic [63:0] lk;
        logic [63:0] s;
        int          r;
        r  = int'(msg_len[3:0]);
        lk = msg_len * K0;
        if (msg_len == 0)
            return K4;
        if (msg_len < 8)
        begin
            s = (K0 ^ (le_word(0, int'(msg_len)) + K3)) * K2;
            return avalanche(s ^ lk);
        end
        if (r >= 9)
            lane_hi = (lane_hi ^ (le_word(8, r - 8) + K1)) * K2;
        if (r >= 8)
            lane_lo = (lane_lo ^ (le_word(0, 8) + K3)) * K2;
        else if (r >= 1)
            lane_lo = (lane_lo ^ (le_word(0, r) + K3)) * K2;
        return lane_lo ^ avalanche(lane_lo ^ lk) ^ avalanche(lane_hi ^ lk);
    endfunction

    assign hashes_pending = hash_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [63:0] want;
        if (!rst_n)
        begin
            lane_lo = K0;
            lane_hi = K1;
            msg_len = '0;
            errors  <= 0;
            hash_queue.delete();
        end
        else
        begin
            if (push && !full)
            begin
                if (byte_valid)
                begin
                    msg_bytes[msg_len[3:0]] = data_byte;
                    msg_len = msg_len + 1;
                    if (msg_len[3:0] == 0)
                    begin
                        lane_lo = (lane_lo ^ (le_word(0, 8) + K3)) * K1;
                        lane_hi = (lane_hi ^ (le_word(8, 8) + K4)) * K2;
                    end
                end
                if (last_item)
                begin
                    hash_queue.push_back(finish_hash());
                    lane_lo = K0;
                    lane_hi = K1;
                    msg_len = '0;
                end
            end
            if (pop && !empty)
            begin
                if (hash_queue.size() == 0)
                begin
                    $display("%0t: unexpected hash %h", $time, hash_value);
                    errors <= errors + 1;
                end
                else
                begin
                    want = hash_queue.pop_front();
                    if (hash_value !== want)
                    begin
                        $display("%0t: hash mismatch expected %h actual %h",
                                 $time, want, hash_value);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/byte_stream_multiply_xor_hash64_top_tb.sv =====
// Testbench top: drives byte messages and pops hashes under several idle patterns.
module byte_stream_multiply_xor_hash64_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last_item;
    logic        push;
    logic        full;
    logic [63:0] hash_value;
    logic        empty;
    logic        pop;
    int          errors;
    int          hashes_pending;
    int          send_idle;
    int          recv_stall;
    bit          hold_off;

    byte_stream_multiply_xor_hash64_top dut (.*);
    byte_stream_multiply_xor_hash64_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #30ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver: random stalls, or a long hold-off
    initial
    begin
        int hold_cycles;
        pop = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                pop = 0;
                for (hold_cycles = 0; hold_cycles < 300; hold_cycles++)
                    @(negedge clk);
                hold_off = 0;
            end
            pop = ($urandom_range(99) >= recv_stall);
        end
    end

    // full only moves at the rising edge, so its value at the falling edge
    // decides the coming accept
    task automatic send(logic [7:0] b, logic v, logic l);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 0;
            @(negedge clk);
        end
        data_byte  <= b;
        byte_valid <= v;
        last_item  <= l;
        push       <= 1;
        while (full)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic send_message(int n, bit all_ff);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(19) == 0)
                send(8'($urandom), 0, 0);
            send(all_ff ? 8'hff : 8'($urandom), 1, (i == n - 1));
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 33);
            if (n == 0)
                send(8'($urandom), 0, 1);
            else if ($urandom_range(7) == 0)
            begin
                send_message(n, 0);
                send(8'($urandom), 0, 1);
            end
            else
                send_message(n, 0);
            sent += n + 1;
        end
    endtask

    initial
    begin
        int waited;
        rst_n = 0; push = 0; data_byte = 0; byte_valid = 0; last_item = 0;
        send_idle = 0; recv_stall = 0; hold_off = 0;
        repeat (6) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // directed: empty message, short lengths, block edges and tails
        send(8'h00, 0, 1);
        send_message(1, 1);
        send_message(7, 1);
        send_message(8, 0);
        send_message(9, 0);
        send_message(16, 1);
        send(8'h00, 1, 0);
        send(8'h55, 0, 0);
        send(8'haa, 0, 1);
        // pressure: hold the receiver off while messages keep coming
        hold_off = 1;
        for (int k = 0; k < 8; k++)
            send_message(2, 0);
        random_phase(300);
        send_idle = 77;
        random_phase(270);
        send_idle = 0; recv_stall = 77;
        random_phase(270);
        send_idle = 14; recv_stall = 14;
        random_phase(270);
        push <= 0;
        waited = 0;
        while (hashes_pending != 0 && waited < 100000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (100) @(negedge clk);
        if (errors == 0 && hashes_pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
